// ===== rtl/ecx_pkg.sv =====
// shared types and constants for the encoder count extender
package ecx_pkg;

   localparam int HALF_W = 16;
   localparam int POS_W  = 32;

   localparam logic [HALF_W-1:0] HALF_MAX = 16'hFFFF;

   // event codes
   localparam logic [2:0] CMD_MATCH  = 3'd0;
   localparam logic [2:0] CMD_UP     = 3'd1;
   localparam logic [2:0] CMD_DOWN   = 3'd2;
   localparam logic [2:0] CMD_WRAP   = 3'd3;
   localparam logic [2:0] CMD_SAMPLE = 3'd4;

   // direction codes
   localparam logic [1:0] DIR_UNKNOWN  = 2'd0;
   localparam logic [1:0] DIR_FORWARD  = 2'd1;
   localparam logic [1:0] DIR_BACKWARD = 2'd2;

   // control register indexes
   localparam logic [1:0] CSR_CHECK_ENABLE     = 2'd0;
   localparam logic [1:0] CSR_CONFIRM_COUNT    = 2'd1;
   localparam logic [1:0] CSR_INVERT_DIRECTION = 2'd2;

   // jitter detector states
   typedef enum logic [4:0] {
      PS_NONE            = 5'b00001,
      PS_FWD_EXP_BWD     = 5'b00010,
      PS_BWD_EXP_FWD     = 5'b00100,
      PS_FWD_EXP_BWD_END = 5'b01000,
      PS_BWD_EXP_FWD_END = 5'b10000
   } pat_state_type;

   typedef struct packed {
      pat_state_type     pstate;
      logic              just_started;
      logic [HALF_W-1:0] pattern_counter;
      logic              comp_started;
      logic [POS_W-1:0]  prev_pulse_position;
   } jit_state_type;

   typedef struct packed {
      logic [2:0]        cmd;
      logic [HALF_W-1:0] hw_count;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0] position;
      logic [POS_W-1:0]        forward_total;
      logic [POS_W-1:0]        backward_total;
      logic [1:0]              direction;
      logic                    compensation_active;
      logic [HALF_W-1:0]       pattern_count;
   } rsp_type;

endpackage

// ===== rtl/ecx_jitter.sv =====
// down-up jitter pattern detector, next-state logic for one event
module ecx_jitter import ecx_pkg::*; (
   input  jit_state_type     cur,
   input  logic              go_up,
   input  logic              go_down,
   input  logic              check_enable,
   input  logic [HALF_W-1:0] confirm_count,
   input  logic [POS_W-1:0]  position,
   output jit_state_type     nxt
);

   jit_state_type     mid;
   logic [HALF_W:0]   cnt_sum;
   logic [HALF_W-1:0] cnt_sat;

   // a moved position restarts the pattern search
   always_comb begin
      mid = cur;
      if (position != cur.prev_pulse_position) begin
         mid.pstate       = PS_NONE;
         mid.just_started = 1'b0;
         if (!cur.comp_started) begin
            mid.pattern_counter = '0;
         end
      end
   end

   // one pattern, or two on the first one after a restart, saturating
   assign cnt_sum = {1'b0, mid.pattern_counter}
                  + (mid.just_started ? (HALF_W+1)'(2) : (HALF_W+1)'(1));
   assign cnt_sat = cnt_sum[HALF_W] ? HALF_MAX : cnt_sum[HALF_W-1:0];

   always_comb begin
      nxt = cur;
      if (check_enable && go_up) begin
         if (cur.pstate == PS_BWD_EXP_FWD) begin
            nxt.pstate = PS_FWD_EXP_BWD_END;
         end
      end else if (check_enable && go_down) begin
         nxt = mid;
         case (mid.pstate)
            PS_NONE: begin
               nxt.just_started = 1'b1;
               nxt.pstate       = PS_BWD_EXP_FWD;
            end
            PS_FWD_EXP_BWD: begin
               nxt.pstate = PS_BWD_EXP_FWD_END;
            end
            PS_FWD_EXP_BWD_END: begin
               nxt.pattern_counter = cnt_sat;
               nxt.just_started    = 1'b0;
               if (confirm_count <= cnt_sat) begin
                  nxt.comp_started = 1'b1;
               end
               nxt.pstate = PS_BWD_EXP_FWD;
            end
            default: begin
               nxt.pstate = mid.pstate;
            end
         endcase
         nxt.prev_pulse_position = position;
      end
   end

endmodule

// ===== rtl/encoder_count_extender_jitter_check.sv =====
// top level: 16 to 32 bit encoder count extension with jitter check and movement totals
//
// takes one counter event per request (compare match, direction up, direction down,
// reload wrap, sample) together with the 16-bit hardware count, and returns one
// response per request: the 32-bit signed position built from the kept upper half
// and the hardware count, the forward and backward movement totals, the direction,
// the jitter pattern count and the compensation flag, all as they stand after the
// event. a request is taken into an input register, its whole update is worked out
// combinationally from that register and the kept state, and the result lands in an
// output register while the state is updated on the same edge, so the next request
// sees it at once. one request per cycle is sustained while the receiver does not
// stall; a response is presented from the output register once its request advances
// and can be accepted at the following edge. the control registers are written
// through the csr port and should only change while no request is in flight.
module encoder_count_extender_jitter_check import ecx_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_payload,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_payload,
   // control register writes
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [HALF_W-1:0] csr_wdata
);

   // control registers
   logic              check_enable_ff;
   logic [HALF_W-1:0] confirm_count_ff;
   logic              invert_ff;

   // input stage
   logic    in_valid_ff, in_valid_in;
   req_type in_req_ff;

   // output stage
   logic    out_valid_ff, out_valid_in;
   rsp_type out_rsp_ff, out_rsp_in;

   // kept state
   logic [HALF_W-1:0] upper_ff, upper_in;
   logic [1:0]        dir_ff, dir_in;
   logic [POS_W-1:0]  last_pos_ff, last_pos_in;
   logic [POS_W-1:0]  fwd_ff, fwd_in;
   logic [POS_W-1:0]  bwd_ff, bwd_in;
   jit_state_type     jit_ff, jit_in;

   logic             advance;
   logic             req_take;
   logic [POS_W-1:0] pos_now;
   logic [POS_W-1:0] delta;
   logic             eff_up;
   logic             eff_down;

   // the input register moves on when the output register is free or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_rsp_ff;

   // position before the event, with the kept upper half
   assign pos_now = {upper_ff, in_req_ff.hw_count};
   assign delta   = pos_now - last_pos_ff;

   // invert swaps what up and down events mean
   assign eff_up   = ((in_req_ff.cmd == CMD_UP) && !invert_ff)
                  || ((in_req_ff.cmd == CMD_DOWN) && invert_ff);
   assign eff_down = ((in_req_ff.cmd == CMD_DOWN) && !invert_ff)
                  || ((in_req_ff.cmd == CMD_UP) && invert_ff);

   ecx_jitter u_jitter (
      .cur           (jit_ff),
      .go_up         (eff_up),
      .go_down       (eff_down),
      .check_enable  (check_enable_ff),
      .confirm_count (confirm_count_ff),
      .position      (pos_now),
      .nxt           (jit_in)
   );

   // extension, direction and movement totals
   always_comb begin
      upper_in    = upper_ff;
      dir_in      = dir_ff;
      last_pos_in = last_pos_ff;
      fwd_in      = fwd_ff;
      bwd_in      = bwd_ff;
      case (in_req_ff.cmd)
         CMD_MATCH: begin
            if (dir_ff == DIR_UNKNOWN) begin
               dir_in = DIR_FORWARD;
            end
         end
         CMD_UP, CMD_DOWN: begin
            dir_in = eff_up ? DIR_FORWARD : DIR_BACKWARD;
         end
         CMD_WRAP: begin
            if (dir_ff == DIR_FORWARD) begin
               upper_in = upper_ff + HALF_W'(1);
            end else if (dir_ff == DIR_BACKWARD) begin
               upper_in = upper_ff - HALF_W'(1);
            end else if (pos_now != '0) begin
               // unknown direction: a nonzero position means we came from below zero
               upper_in = upper_ff - HALF_W'(1);
               dir_in   = DIR_BACKWARD;
            end else begin
               upper_in = upper_ff + HALF_W'(1);
               dir_in   = DIR_FORWARD;
            end
         end
         CMD_SAMPLE: begin
            // signed change since the last sample goes to one of the totals
            if (delta[POS_W-1]) begin
               bwd_in = bwd_ff - delta;
            end else begin
               fwd_in = fwd_ff + delta;
            end
            last_pos_in = pos_now;
         end
         default: begin
            upper_in = upper_ff;
         end
      endcase
   end

   // response reflects the state after the event
   always_comb begin
      out_rsp_in.position            = {upper_in, in_req_ff.hw_count};
      out_rsp_in.forward_total       = fwd_in;
      out_rsp_in.backward_total      = bwd_in;
      out_rsp_in.direction           = dir_in;
      out_rsp_in.compensation_active = jit_in.comp_started;
      out_rsp_in.pattern_count       = jit_in.pattern_counter;
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // control and kept state
   always_ff @(posedge clock) begin
      if (reset) begin
         check_enable_ff  <= 1'b0;
         confirm_count_ff <= '0;
         invert_ff        <= 1'b0;
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         upper_ff         <= '0;
         dir_ff           <= DIR_UNKNOWN;
         last_pos_ff      <= '0;
         fwd_ff           <= '0;
         bwd_ff           <= '0;
         jit_ff.pstate              <= PS_NONE;
         jit_ff.just_started        <= 1'b0;
         jit_ff.pattern_counter     <= '0;
         jit_ff.comp_started        <= 1'b0;
         jit_ff.prev_pulse_position <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CHECK_ENABLE:     check_enable_ff  <= csr_wdata[0];
               CSR_CONFIRM_COUNT:    confirm_count_ff <= csr_wdata;
               CSR_INVERT_DIRECTION: invert_ff        <= csr_wdata[0];
               default:              invert_ff        <= invert_ff;
            endcase
         end
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            upper_ff    <= upper_in;
            dir_ff      <= dir_in;
            last_pos_ff <= last_pos_in;
            fwd_ff      <= fwd_in;
            bwd_ff      <= bwd_in;
            jit_ff      <= jit_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_req_ff <= req_payload;
      end
      if (advance) begin
         out_rsp_ff <= out_rsp_in;
      end
   end

`ifndef NO_ASSERTIONS
   // compensation, once declared, is only cleared by reset
   a_comp_sticky: assert property (@(posedge clock) disable iff (reset)
      (!reset && jit_ff.comp_started) |=> jit_ff.comp_started)
      else $error("compensation flag dropped");

   // kept state moves only when a request advances into the output register
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      (!reset && !advance) |=> ($stable(upper_ff) && $stable(fwd_ff) && $stable(bwd_ff)
                                && $stable(dir_ff)))
      else $error("state changed without an advancing request");

   // detector is frozen while checking is off
   a_jit_idle: assert property (@(posedge clock) disable iff (reset)
      (!reset && !check_enable_ff) |=> $stable(jit_ff))
      else $error("jitter detector moved with checking disabled");

   // a held response is never overwritten by an advancing request
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |-> !advance)
      else $error("result register overwritten while stalled");
`endif

endmodule

// ===== tb/sv/encoder_count_extender_jitter_check_tb.sv =====
// self-checking testbench for the encoder count extender with jitter check
module encoder_count_extender_jitter_check_tb;
   import ecx_pkg::*;

   // spare event codes that the block must ignore
   localparam logic [2:0] CMD_SPARE_LO = 3'd5;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;

   // cycles without any accepted request or response before the run is declared hung
   localparam int WATCHDOG_LIMIT = 2000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_type           req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_payload;
   logic              csr_we = 1'b0;
   logic [1:0]        csr_index = CSR_CHECK_ENABLE;
   logic [HALF_W-1:0] csr_wdata = '0;

   encoder_count_extender_jitter_check u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------
   // mirror of the block: control registers and kept state
   // ---------------------------------------------------------------
   logic              cfg_check   = 1'b0;
   logic [HALF_W-1:0] cfg_confirm = '0;
   logic              cfg_invert  = 1'b0;

   logic [HALF_W-1:0] ext_upper    = '0;
   logic [1:0]        ext_dir      = DIR_UNKNOWN;
   logic [POS_W-1:0]  ext_last_pos = '0;
   logic [POS_W-1:0]  ext_fwd      = '0;
   logic [POS_W-1:0]  ext_bwd      = '0;

   pat_state_type     jit_state    = PS_NONE;
   logic [POS_W-1:0]  jit_prev_pos = '0;
   logic              jit_fresh    = 1'b0;
   logic [HALF_W-1:0] jit_count    = '0;
   logic              jit_comp     = 1'b0;

   // responses still owed by the block, oldest first
   rsp_type           expected_rsp_q[$];
   rsp_type           rsp_want;

   int                error_count = 0;
   int                req_count   = 0;
   int                quiet_run   = 0;
   bit                quiet_mode  = 1'b0;
   int                rsp_hold    = 0;

   // apply one event to the mirror and build the response it should give
   task automatic extend_event(input logic [2:0] cmd, input logic [HALF_W-1:0] hw,
                               output rsp_type r);
      logic [POS_W-1:0] pos;
      logic [POS_W-1:0] delta;
      logic             eff_up;
      logic             eff_down;
      pos      = {ext_upper, hw};
      // invert swaps the two direction events, nothing else
      eff_up   = (cmd == CMD_UP && !cfg_invert) || (cmd == CMD_DOWN && cfg_invert);
      eff_down = (cmd == CMD_DOWN && !cfg_invert) || (cmd == CMD_UP && cfg_invert);
      case (cmd)
         CMD_MATCH: begin
            if (ext_dir == DIR_UNKNOWN)
               ext_dir = DIR_FORWARD;
         end
         CMD_WRAP: begin
            if (ext_dir == DIR_FORWARD) begin
               ext_upper = ext_upper + 1'b1;
            end else if (ext_dir == DIR_BACKWARD) begin
               ext_upper = ext_upper - 1'b1;
            end else if (pos != '0) begin
               // no direction yet: a nonzero position means underflow
               ext_upper = ext_upper - 1'b1;
               ext_dir   = DIR_BACKWARD;
            end else begin
               ext_upper = ext_upper + 1'b1;
               ext_dir   = DIR_FORWARD;
            end
         end
         CMD_SAMPLE: begin
            delta = pos - ext_last_pos;
            if (delta != '0) begin
               if (!delta[POS_W-1])
                  ext_fwd = ext_fwd + delta;
               else
                  ext_bwd = ext_bwd - delta;
            end
            ext_last_pos = pos;
         end
         default: ;
      endcase
      if (eff_up) begin
         ext_dir = DIR_FORWARD;
         if (cfg_check && jit_state == PS_BWD_EXP_FWD)
            jit_state = PS_FWD_EXP_BWD_END;
      end
      if (eff_down) begin
         ext_dir = DIR_BACKWARD;
         if (cfg_check) begin
            // a move since the last down pulse restarts the detector
            if (pos != jit_prev_pos) begin
               jit_state = PS_NONE;
               jit_fresh = 1'b0;
               if (!jit_comp)
                  jit_count = '0;
            end
            case (jit_state)
               PS_NONE: begin
                  jit_fresh = 1'b1;
                  jit_state = PS_BWD_EXP_FWD;
               end
               PS_FWD_EXP_BWD: jit_state = PS_BWD_EXP_FWD_END;
               PS_FWD_EXP_BWD_END: begin
                  if (jit_count != HALF_MAX)
                     jit_count = jit_count + 1'b1;
                  // the first pattern of a run counts twice
                  if (jit_fresh) begin
                     jit_fresh = 1'b0;
                     if (jit_count != HALF_MAX)
                        jit_count = jit_count + 1'b1;
                  end
                  if (!jit_comp && cfg_confirm <= jit_count)
                     jit_comp = 1'b1;
                  jit_state = PS_BWD_EXP_FWD;
               end
               default: ;
            endcase
            jit_prev_pos = pos;
         end
      end
      r.position            = {ext_upper, hw};
      r.forward_total       = ext_fwd;
      r.backward_total      = ext_bwd;
      r.direction           = ext_dir;
      r.compensation_active = jit_comp;
      r.pattern_count       = jit_count;
   endtask

   // ---------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------

   // offer one request, hold it until taken, then record what it should produce
   task automatic send_req(input logic [2:0] cmd, input logic [HALF_W-1:0] hw);
      req_type item;
      rsp_type r;
      // random gap on the sender side
      if (!quiet_mode && $urandom_range(99) < 33) begin
         repeat ($urandom_range(1, 4)) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      item.cmd      = cmd;
      item.hw_count = hw;
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= item;
      // valid stays high past the taking edge until the next falling edge,
      // where the caller either offers the next request or drops valid
      do
         @(posedge clock);
      while (req_stall);
      extend_event(cmd, hw, r);
      expected_rsp_q.push_back(r);
      req_count++;
   endtask

   // drop valid and let every owed response come back, then idle a while longer
   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [HALF_W-1:0] data);
      @(negedge clock);
      req_valid <= 1'b0;
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_CHECK_ENABLE:     cfg_check   = data[0];
         CSR_CONFIRM_COUNT:    cfg_confirm = data;
         CSR_INVERT_DIRECTION: cfg_invert  = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // registers change only with the block empty
   task automatic configure(input logic chk, input logic [HALF_W-1:0] confirm,
                            input logic inv);
      drain();
      write_csr(CSR_CHECK_ENABLE, {15'd0, chk});
      write_csr(CSR_CONFIRM_COUNT, confirm);
      write_csr(CSR_INVERT_DIRECTION, {15'd0, inv});
   endtask

   function automatic logic [HALF_W-1:0] pick_hw();
      case ($urandom_range(5))
         0:       return '0;
         1:       return HALF_MAX;
         default: return HALF_W'($urandom);
      endcase
   endfunction

   // one random burst: mostly jitter and motion sequences, some noise
   task automatic send_burst;
      int               kind;
      int               steps;
      logic [HALF_W-1:0] hw;
      logic [2:0]       lead;
      logic [2:0]       trail;
      kind = $urandom_range(99);
      hw   = pick_hw();
      if (kind < 45) begin
         // down/up chatter at one position, now and then a real move
         lead  = $urandom_range(1) ? CMD_DOWN : CMD_UP;
         trail = (lead == CMD_DOWN) ? CMD_UP : CMD_DOWN;
         steps = $urandom_range(1, 8);
         repeat (steps) begin
            if ($urandom_range(15) == 0)
               hw = pick_hw();
            send_req(lead, hw);
            if ($urandom_range(15) == 0)
               hw = pick_hw();
            send_req(trail, hw);
         end
      end else if (kind < 75) begin
         // set a direction, then walk the count with samples and wraps
         send_req($urandom_range(1) ? CMD_UP : CMD_DOWN, hw);
         steps = $urandom_range(2, 8);
         repeat (steps) begin
            if ($urandom_range(7) == 0)
               hw = HALF_W'($urandom);
            else
               hw = hw + HALF_W'($urandom_range(4000)) - HALF_W'(2000);
            if ($urandom_range(3) == 0)
               send_req(CMD_WRAP, hw);
            send_req(CMD_SAMPLE, hw);
         end
      end else if (kind < 85) begin
         send_req(CMD_MATCH, hw);
         send_req(CMD_WRAP, pick_hw());
         send_req(CMD_SAMPLE, pick_hw());
      end else begin
         // noise: any code, any count
         steps = $urandom_range(1, 4);
         repeat (steps)
            send_req(3'($urandom_range(7)), HALF_W'($urandom));
      end
   endtask

   // ---------------------------------------------------------------
   // response side
   // ---------------------------------------------------------------

   // receiver stall: a counted hold-off when asked, else random or none
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold = rsp_hold - 1;
      end else if (quiet_mode) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 33);
      end
   end

   task automatic report_mismatch(input string what, input logic [POS_W-1:0] want,
                                  input logic [POS_W-1:0] got);
      error_count++;
      $display("%0t mismatch %s: expected %h actual %h", $time, what, want, got);
   endtask

   // compare each taken response with the oldest owed one
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp_q.size() == 0) begin
            error_count++;
            $display("%0t unexpected response: expected none actual %h",
                     $time, rsp_payload);
         end else begin
            rsp_want = expected_rsp_q.pop_front();
            if (rsp_payload.position !== rsp_want.position)
               report_mismatch("position", rsp_want.position, rsp_payload.position);
            if (rsp_payload.forward_total !== rsp_want.forward_total)
               report_mismatch("forward_total", rsp_want.forward_total,
                               rsp_payload.forward_total);
            if (rsp_payload.backward_total !== rsp_want.backward_total)
               report_mismatch("backward_total", rsp_want.backward_total,
                               rsp_payload.backward_total);
            if (rsp_payload.direction !== rsp_want.direction)
               report_mismatch("direction", 32'(rsp_want.direction),
                               32'(rsp_payload.direction));
            if (rsp_payload.compensation_active !== rsp_want.compensation_active)
               report_mismatch("compensation_active", 32'(rsp_want.compensation_active),
                               32'(rsp_payload.compensation_active));
            if (rsp_payload.pattern_count !== rsp_want.pattern_count)
               report_mismatch("pattern_count", 32'(rsp_want.pattern_count),
                               32'(rsp_payload.pattern_count));
         end
      end
   end

   // hang detector: nothing moving on either channel for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_run = 0;
      else
         quiet_run = quiet_run + 1;
      if (quiet_run >= WATCHDOG_LIMIT) begin
         $display("%0t watchdog: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // direction is unknown only right after reset, so one of its three
   // cases is picked at random: match, wrap at zero, wrap off zero
   task automatic test_unknown_direction;
      send_req(CMD_SPARE_LO, HALF_MAX);
      case ($urandom_range(2))
         0:       send_req(CMD_MATCH, HALF_W'($urandom));
         1:       send_req(CMD_WRAP, '0);
         default: send_req(CMD_WRAP, HALF_W'($urandom_range(1, 65535)));
      endcase
   endtask

   // spare codes, samples, wraps, a match and a down event at the count extremes, detector off
   task automatic test_directed_events;
      send_req(CMD_SPARE_HI, '0);
      send_req(3'd6, HALF_W'($urandom));
      send_req(CMD_SAMPLE, HALF_MAX);
      send_req(CMD_SAMPLE, '0);            // negative change
      send_req(CMD_SAMPLE, '0);            // no change
      send_req(CMD_WRAP, HALF_MAX);
      send_req(CMD_MATCH, 16'h8000);       // direction already known
      send_req(CMD_DOWN, 16'h0001);
      send_req(CMD_WRAP, 16'h0001);        // backward wrap
      send_req(CMD_SAMPLE, 16'h7FFF);
   endtask

   // detector: start, count with the double first pattern, restart on a move
   task automatic test_jitter_patterns;
      configure(1'b1, HALF_MAX, 1'b0);
      send_req(CMD_DOWN, 16'h1234);
      send_req(CMD_UP, 16'h1234);
      send_req(CMD_DOWN, 16'h1234);
      send_req(CMD_UP, 16'h1234);
      send_req(CMD_DOWN, 16'h1234);
      send_req(CMD_DOWN, 16'h1235);        // moved: restart
      send_req(CMD_UP, 16'h1235);
      send_req(CMD_DOWN, 16'h1235);
      // inverted: up events act as down pulses
      configure(1'b1, HALF_MAX, 1'b1);
      send_req(CMD_UP, 16'hFFFF);
      send_req(CMD_DOWN, 16'hFFFF);
      send_req(CMD_UP, 16'hFFFF);
      // detector off, zero threshold: direction only
      configure(1'b0, '0, 1'b0);
      send_req(CMD_DOWN, 16'hFFFF);
      send_req(CMD_UP, 16'hFFFF);
      send_req(CMD_DOWN, 16'hFFFF);
   endtask

   // random phases; early ones keep the threshold out of reach so that the
   // counter clearing stays visible, late ones run with compensation on
   task automatic test_random_traffic(input int phases, input int per_phase,
                                      input bit late);
      int               start;
      logic [HALF_W-1:0] confirm;
      for (int p = 0; p < phases; p++) begin
         if (!late) begin
            confirm = HALF_MAX;
         end else begin
            case ($urandom_range(3))
               0:       confirm = '0;
               1:       confirm = HALF_MAX;
               2:       confirm = HALF_W'($urandom_range(1, 20));
               default: confirm = HALF_W'($urandom);
            endcase
         end
         configure($urandom_range(3) != 0, confirm, 1'($urandom_range(1)));
         // one phase runs with no idling on either side
         quiet_mode = (p == 1);
         start = req_count;
         while (req_count - start < per_phase)
            send_burst();
         quiet_mode = 1'b0;
      end
   endtask

   // receiver holds off while the sender keeps offering, so the block fills
   // and stalls its requests
   task automatic test_backpressure;
      drain();
      rsp_hold = 300;
      repeat (60)
         send_req(3'($urandom_range(4)), HALF_W'($urandom));
   endtask

   // long chatter at one position with no idling; the pattern counter climbs one per
   // completed pattern, two for the first pattern, and passes the threshold part way through
   task automatic test_pattern_run;
      logic [HALF_W-1:0] hw;
      configure(1'b1, HALF_W'(120), 1'b0);
      quiet_mode = 1'b1;
      hw = HALF_W'($urandom);
      send_req(CMD_DOWN, hw);
      repeat (200) begin
         send_req(CMD_UP, hw);
         send_req(CMD_DOWN, hw);
      end
      quiet_mode = 1'b0;
   endtask

   initial begin
      // synchronous reset, applied once
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_unknown_direction();
      test_directed_events();
      test_jitter_patterns();
      test_random_traffic(5, 80, 1'b0);
      test_backpressure();
      test_pattern_run();
      test_random_traffic(5, 80, 1'b1);

      drain();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
